[rtl/sarc_pkg.sv]
// Shared types, codes and constants of the sensor average, reject and calibrate block.
package sarc_pkg;

  localparam int WINDOW_DEF      = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int RAW_W      = 16;
  localparam int TEMP_W     = 14;
  localparam int NF_W       = 16;
  localparam int TC_W       = 16;
  localparam int GAIN_W     = 32;
  localparam int OFFSET_W   = 32;
  localparam int CONC_W     = 32;
  localparam int AVG_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  localparam logic [TEMP_W-1:0]          REF_TEMP       = 14'd3700;
  localparam logic [TEMP_W-1:0]          LIMIT_RESET    = 14'd200;
  localparam logic [NF_W-1:0]            NOISE_RESET    = 16'd3277;
  localparam logic signed [TC_W-1:0]     COEFF_RESET    = 16'sd1678;
  localparam logic signed [GAIN_W-1:0]   GAIN_RESET     = 32'sd65536;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET   = 32'sd0;
  localparam logic signed [31:0]         FACTOR_ONE     = 32'sh0100_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_STEP_LIMIT = 3'd0,
    REG_NOISE_FRACTION  = 3'd1,
    REG_TEMP_COEFF      = 3'd2,
    REG_CAL_GAIN        = 3'd3,
    REG_CAL_OFFSET      = 3'd4
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNSTABLE = 2'd1,
    ST_NOISY    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEMP,
    S_READ,
    S_DIV,
    S_NOISE,
    S_MULHI,
    S_MULLO,
    S_SUM,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic temp_ok;
    logic ring_upd;
    logic mul_comp;
    logic mul_hi;
    logic mul_lo;
    logic set_unstable;
    logic set_noisy;
    logic set_ok;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic temp_bad;
    logic div_done;
    logic noisy;
    logic out_free;
  } sts_t;

endpackage

[rtl/sarc_div.sv]
// Restoring divider, one quotient bit per cycle.
module sarc_div #(
  parameter int DW = 20,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] den;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial    = {rem, quo[DW-1]};
  assign ge       = trial >= {1'b0, den};
  assign diff     = trial - {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CW'(DW - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

endmodule

[rtl/sarc_ctrl.sv]
// Controller state machine sequencing one item through the datapath.
module sarc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  sarc_pkg::sts_t sts,
  output sarc_pkg::cmd_t cmd
);

  import sarc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_TEMP;
      S_TEMP:  state_next = sts.temp_bad ? S_EMIT : S_READ;
      S_READ:  state_next = S_DIV;
      S_DIV:   if (sts.div_done) state_next = S_NOISE;
      S_NOISE: state_next = sts.noisy ? S_EMIT : S_MULHI;
      S_MULHI: state_next = S_MULLO;
      S_MULLO: state_next = S_SUM;
      S_SUM:   state_next = S_EMIT;
      S_EMIT:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      S_TEMP: begin
        cmd.set_unstable = sts.temp_bad;
        cmd.temp_ok      = !sts.temp_bad;
      end
      S_READ:  cmd.ring_upd = 1'b1;
      S_DIV:   ;
      S_NOISE: begin
        cmd.set_noisy = sts.noisy;
        cmd.mul_comp  = !sts.noisy;
      end
      S_MULHI: cmd.mul_hi   = 1'b1;
      S_MULLO: cmd.mul_lo   = 1'b1;
      S_SUM:   cmd.set_ok   = 1'b1;
      S_EMIT:  cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.set_ok |-> $past(cmd.mul_lo) && $past(cmd.mul_hi, 2))
    else $error("calibration sum without both partial products");

  assert property (@(posedge clk) disable iff (rst)
    cmd.ring_upd |-> $past(cmd.temp_ok))
    else $error("ring update without a passed temperature check");

endmodule

[rtl/sarc_datapath.sv]
// Datapath: registers, sample ring, running sum, noise test and calibration arithmetic.
module sarc_datapath #(
  parameter int WINDOW      = sarc_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = sarc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [sarc_pkg::RAW_W-1:0]             raw_sample,
  input  logic [sarc_pkg::TEMP_W-1:0]            temperature,
  input  logic                                   cfg_valid,
  input  logic [sarc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sarc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  sarc_pkg::cmd_t                         cmd,
  output sarc_pkg::sts_t                         sts,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [sarc_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic [sarc_pkg::STATUS_W-1:0]          m_tuser
);

  import sarc_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SB + CNT_W;
  localparam int COMP_W = SB + 9;
  localparam int HI_W   = COMP_W - 16;
  localparam int PHI_W  = GAIN_W + HI_W;
  localparam int YW     = SB + 27;

  // configuration
  logic [TEMP_W-1:0]          temp_step_limit;
  logic [NF_W-1:0]            noise_fraction;
  logic signed [TC_W-1:0]     temp_coeff;
  logic signed [GAIN_W-1:0]   cal_gain;
  logic signed [OFFSET_W-1:0] cal_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_step_limit <= LIMIT_RESET;
      noise_fraction  <= NOISE_RESET;
      temp_coeff      <= COEFF_RESET;
      cal_gain        <= GAIN_RESET;
      cal_offset      <= OFFSET_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEMP_STEP_LIMIT: temp_step_limit <= cfg_data[TEMP_W-1:0];
        REG_NOISE_FRACTION:  noise_fraction  <= cfg_data[NF_W-1:0];
        REG_TEMP_COEFF:      temp_coeff      <= $signed(cfg_data[TC_W-1:0]);
        REG_CAL_GAIN:        cal_gain        <= $signed(cfg_data[GAIN_W-1:0]);
        REG_CAL_OFFSET:      cal_offset      <= $signed(cfg_data[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  // captured item
  logic [SB-1:0]     sample_r;
  logic [TEMP_W-1:0] temp_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= SB'(raw_sample);
      temp_r   <= temperature;
    end
  end

  // temperature check and factor
  logic [TEMP_W-1:0]   last_temp;
  logic [TEMP_W-1:0]   tdiff;
  logic signed [14:0]  tdelta;
  logic signed [30:0]  tprod;
  logic signed [31:0]  factor_r;

  assign tdiff        = (temp_r > last_temp) ? temp_r - last_temp : last_temp - temp_r;
  assign sts.temp_bad = tdiff > temp_step_limit;
  assign tdelta       = $signed({1'b0, temp_r}) - $signed({1'b0, REF_TEMP});
  assign tprod        = temp_coeff * tdelta;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp <= REF_TEMP;
    end else if (cmd.temp_ok) begin
      last_temp <= temp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.temp_ok) begin
      factor_r <= FACTOR_ONE + 32'(tprod);
    end
  end

  // sample ring and running sum
  logic [SB-1:0]     ring [WINDOW];
  logic [SB-1:0]     ring_q;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic              full;
  logic              full_next;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count;
  logic              wrap;

  always_ff @(posedge clk) begin
    if (cmd.temp_ok) begin
      ring_q <= ring[slot];
    end
    if (cmd.ring_upd) begin
      ring[slot] <= sample_r;
    end
  end

  assign wrap      = int'(slot) == WINDOW - 1;
  assign slot_next = wrap ? '0 : slot + 1'b1;
  assign full_next = full || wrap;
  assign sum_next  = sum - (full ? SUM_W'(ring_q) : '0) + SUM_W'(sample_r);
  assign count     = full_next ? CNT_W'(WINDOW) : CNT_W'(slot_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      full <= 1'b0;
      sum  <= '0;
    end else if (cmd.ring_upd) begin
      slot <= slot_next;
      full <= full_next;
      sum  <= sum_next;
    end
  end

  // average
  logic [SUM_W-1:0] quotient;
  logic [SB-1:0]    avg;

  sarc_div #(
    .DW(SUM_W),
    .VW(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.ring_upd),
    .dividend (sum_next),
    .divisor  (count),
    .done     (sts.div_done),
    .quotient (quotient)
  );

  assign avg = quotient[SB-1:0];

  // noise test
  logic [SB-1:0]    dev;
  logic [SB+15:0]   dev_sh;
  logic [SB+15:0]   nlim;

  assign dev       = (sample_r > avg) ? sample_r - avg : avg - sample_r;
  assign dev_sh    = {dev, 16'b0};
  assign nlim      = noise_fraction * avg;
  assign sts.noisy = !(dev_sh < nlim);

  // calibration
  logic signed [SB+32:0]     comp_full;
  logic signed [COMP_W-1:0]  comp_r;
  logic signed [HI_W-1:0]    comp_hi;
  logic [15:0]               comp_lo;
  logic signed [PHI_W-1:0]   p_hi_full;
  logic signed [PHI_W-1:0]   p_hi_r;
  logic signed [48:0]        p_lo_full;
  logic signed [32:0]        p_lo_r;
  logic signed [YW-1:0]      y;
  logic [CONC_W-1:0]         y_sat;

  assign comp_full = $signed({1'b0, avg}) * factor_r;
  assign comp_hi   = comp_r[COMP_W-1:16];
  assign comp_lo   = comp_r[15:0];
  assign p_hi_full = cal_gain * comp_hi;
  assign p_lo_full = cal_gain * $signed({1'b0, comp_lo});
  assign y         = YW'(p_hi_r) + YW'(p_lo_r) + YW'(cal_offset);

  always_comb begin
    if (&y[YW-1:CONC_W-1] || ~|y[YW-1:CONC_W-1]) begin
      y_sat = y[CONC_W-1:0];
    end else if (y[YW-1]) begin
      y_sat = {1'b1, {(CONC_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(CONC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_comp) begin
      comp_r <= comp_full[SB+32:24];
    end
    if (cmd.mul_hi) begin
      p_hi_r <= p_hi_full;
    end
    if (cmd.mul_lo) begin
      p_lo_r <= p_lo_full[48:16];
    end
  end

  // result and output register
  status_t           res_status;
  logic [CONC_W-1:0] res_conc;
  logic [AVG_W-1:0]  res_avg;
  status_t           out_status;
  logic [CONC_W-1:0] out_conc;
  logic [AVG_W-1:0]  out_avg;

  always_ff @(posedge clk) begin
    if (cmd.set_unstable) begin
      res_status <= ST_UNSTABLE;
      res_conc   <= '0;
      res_avg    <= '0;
    end else if (cmd.set_noisy) begin
      res_status <= ST_NOISY;
      res_conc   <= '0;
      res_avg    <= AVG_W'(avg);
    end else if (cmd.set_ok) begin
      res_status <= ST_OK;
      res_conc   <= y_sat;
      res_avg    <= AVG_W'(avg);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_conc   <= res_conc;
      out_avg    <= res_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign sts.out_free = !m_tvalid || m_tready;
  assign m_tdata      = {out_avg, out_conc};
  assign m_tuser      = out_status;

  assert property (@(posedge clk) disable iff (rst)
    int'(slot) < WINDOW)
    else $error("ring slot out of range");

  assert property (@(posedge clk) disable iff (rst)
    cmd.ring_upd |-> $past(cmd.temp_ok))
    else $error("ring written without reading the old entry first");

  assert property (@(posedge clk) disable iff (rst)
    cmd.set_ok |-> avg != '0)
    else $error("zero average passed the noise test");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid && m_tuser == $past(res_status))
    else $error("result not presented after load");

endmodule

[rtl/sensor_average_reject_calibrate.sv]
// Top level of the moving average sensor block with outlier rejection and calibration.
//
// channel  dir  handshake            payload
// s        in   s_tvalid / s_tready  tdata: raw_sample, temperature
// m        out  m_tvalid / m_tready  tdata: concentration, window_average; tuser: status
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item rejected for temperature skips the ring, the divider and the calibration; a noisy
// item skips only the calibration. The divider is SUM_W = SAMPLE_BITS + clog2(WINDOW + 1)
// bits wide (20 at defaults) and finds one quotient bit per cycle.
// Reset is synchronous; no clearing pass, the old ring entry is used only once written.
// The output register holds a result while m_tready is low; the next item is
// still accepted, and its result waits until that register is free.
module sensor_average_reject_calibrate #(
  parameter int WINDOW      = sarc_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = sarc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sarc_pkg::IN_DATA_W-1:0]   s_tdata,   // raw_sample[15:0], temperature[29:16]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sarc_pkg::OUT_DATA_W-1:0]  m_tdata,   // concentration[31:0], window_average[47:32]
  output logic [sarc_pkg::STATUS_W-1:0]    m_tuser,   // status[1:0]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sarc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sarc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sarc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic unused_pad;

  assign cfg_ready  = 1'b1;
  assign unused_pad = ^s_tdata[IN_DATA_W-1:RAW_W+TEMP_W];

  sarc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sarc_datapath #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .raw_sample  (s_tdata[RAW_W-1:0]),
    .temperature (s_tdata[RAW_W+TEMP_W-1:RAW_W]),
    .cfg_valid   (cfg_valid && !unused_pad || cfg_valid && unused_pad),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

[tb/sv/sensor_average_reject_calibrate_tb.sv]
// Self-checking testbench for the sensor moving average, reject and calibrate block.
module sensor_average_reject_calibrate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sarc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int TEMP_MAX     = (1 << TEMP_W) - 1;
  localparam int RAW_MAX      = (1 << RAW_W) - 1;
  localparam int LIMIT_MAX    = 10000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam longint CONC_MAX = 64'sd2147483647;
  localparam longint CONC_MIN = -64'sd2147483648;

  typedef struct {
    logic [RAW_W-1:0]  raw;
    logic [TEMP_W-1:0] temp;
  } sample_item_t;

  typedef struct {
    status_t           status;
    logic [CONC_W-1:0] conc;
    logic [AVG_W-1:0]  avg;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // raw_sample[15:0], temperature[29:16]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // concentration[31:0], window_average[47:32]
  logic [STATUS_W-1:0]   m_tuser;        // status[1:0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sensor_average_reject_calibrate dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // filter state and register copy
  logic [RAW_W-1:0]         ring_q [WINDOW_DEF];
  int unsigned              slot_q = 0;
  bit                       full_q = 1'b0;
  int unsigned              sum_q = 0;
  int unsigned              last_temp_q = REF_TEMP;
  logic [TEMP_W-1:0]        limit_q = LIMIT_RESET;
  logic [NF_W-1:0]          nf_q = NOISE_RESET;
  logic signed [TC_W-1:0]   coeff_q = COEFF_RESET;
  logic signed [GAIN_W-1:0] gain_q = GAIN_RESET;
  logic signed [OFFSET_W-1:0] offset_q = OFFSET_RESET;

  sample_item_t pending_samples[$];
  reading_t     expected_readings[$];

  bit s_taken = 1'b0;
  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  int src_gap = 0;
  int sink_wait = 0;
  int long_hold_cycles = 0;
  int cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int n_ok = 0;
  int n_unstable = 0;
  int n_noisy = 0;
  int reg_writes = 0;

  // generator view of the temperature gate
  int gen_temp = REF_TEMP;
  int gen_limit = LIMIT_RESET;
  int gen_nf = NOISE_RESET;

  function automatic reading_t average_and_calibrate(logic [RAW_W-1:0] raw,
                                                     logic [TEMP_W-1:0] temp);
    reading_t    r;
    int unsigned tdiff;
    int unsigned cnt;
    longint      avg;
    longint      dev;
    longint      factor;
    longint      comp;
    longint      y;
    r.status = ST_OK;
    r.conc = '0;
    r.avg = '0;
    tdiff = (temp > last_temp_q) ? temp - last_temp_q : last_temp_q - temp;
    if (tdiff > limit_q) begin
      r.status = ST_UNSTABLE;
      return r;
    end
    last_temp_q = temp;
    if (full_q) sum_q -= ring_q[slot_q];
    ring_q[slot_q] = raw;
    sum_q += raw;
    slot_q++;
    if (slot_q == WINDOW_DEF) begin
      slot_q = 0;
      full_q = 1'b1;
    end
    cnt = full_q ? WINDOW_DEF : slot_q;
    avg = longint'(sum_q / cnt);
    r.avg = avg[AVG_W-1:0];
    dev = longint'(raw) - avg;
    if (dev < 0) dev = -dev;
    if (!((dev << 16) < longint'(nf_q) * avg)) begin
      r.status = ST_NOISY;
      return r;
    end
    factor = (longint'(1) << 24) + longint'(coeff_q) * (longint'(temp) - longint'(REF_TEMP));
    comp = (avg * factor) >>> 24;
    y = ((longint'(gain_q) * comp) >>> 16) + longint'(offset_q);
    if (y > CONC_MAX) y = CONC_MAX;
    if (y < CONC_MIN) y = CONC_MIN;
    r.conc = y[CONC_W-1:0];
    return r;
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_TEMP_STEP_LIMIT: limit_q = val[TEMP_W-1:0];
      REG_NOISE_FRACTION:  nf_q = val[NF_W-1:0];
      REG_TEMP_COEFF:      coeff_q = val[TC_W-1:0];
      REG_CAL_GAIN:        gain_q = val[GAIN_W-1:0];
      REG_CAL_OFFSET:      offset_q = val[OFFSET_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 40)
      $display("ERROR result %0d %s: expected %0h, got %0h", results_seen, what, want, got);
  endtask

  // sender
  always @(negedge clk) begin
    sample_item_t nxt;
    if (!s_tvalid || s_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        nxt = pending_samples.pop_front();
        s_tdata <= {{(IN_DATA_W-RAW_W-TEMP_W){1'b0}}, nxt.temp, nxt.raw};
        s_tvalid <= 1'b1;
        src_gap = src_gaps_on ? pick_gap() : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (long_hold_cycles > 0) begin
      sink_wait = long_hold_cycles;
      long_hold_cycles = 0;
    end
    if (sink_wait > 0) begin
      m_tready <= 1'b0;
      sink_wait--;
    end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      sink_wait = pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      s_taken <= 1'b0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        load_register(cfg_index, cfg_data);
        reg_writes++;
      end
      if (s_tvalid && s_tready)
        expected_readings.push_back(
          average_and_calibrate(s_tdata[RAW_W-1:0], s_tdata[RAW_W +: TEMP_W]));
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected transaction", 0, m_tdata);
        end else begin
          want = expected_readings.pop_front();
          if (m_tuser !== want.status) report_mismatch("status", want.status, m_tuser);
          if (m_tdata[CONC_W-1:0] !== want.conc)
            report_mismatch("concentration", want.conc, m_tdata[CONC_W-1:0]);
          if (m_tdata[CONC_W +: AVG_W] !== want.avg)
            report_mismatch("window_average", want.avg, m_tdata[CONC_W +: AVG_W]);
          case (want.status)
            ST_OK:       n_ok++;
            ST_UNSTABLE: n_unstable++;
            default:     n_noisy++;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_readings.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_item(int raw, int temp);
    sample_item_t it;
    int           d;
    it.raw = raw[RAW_W-1:0];
    it.temp = temp[TEMP_W-1:0];
    d = temp - gen_temp;
    if (d < 0) d = -d;
    if (d <= gen_limit) gen_temp = temp;
    pending_samples.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TEMP_STEP_LIMIT) gen_limit = int'(val[TEMP_W-1:0]);
    if (idx == REG_NOISE_FRACTION) gen_nf = int'(val[NF_W-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int lim, int nf, logic [15:0] coeff, logic [31:0] gain,
                          logic [31:0] off);
    write_reg(REG_TEMP_STEP_LIMIT, lim);
    write_reg(REG_NOISE_FRACTION, nf);
    write_reg(REG_TEMP_COEFF, {16'h0, coeff});
    write_reg(REG_CAL_GAIN, gain);
    write_reg(REG_CAL_OFFSET, off);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // mostly steady temperature and level, with spikes, temperature jumps and noise
  task automatic random_burst(int n, int level);
    int r;
    int t;
    int raw;
    int step;
    int spread;
    int lvl;
    lvl = level;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) == 0) lvl = $urandom_range(0, RAW_MAX);
      spread = int'((longint'(lvl) * gen_nf) >>> 18);
      step = (gen_limit < 150) ? gen_limit : 150;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        t = clamp(gen_temp - step + int'($urandom_range(0, 2 * step)), 0, TEMP_MAX);
      end else if (r < 88) begin
        if (gen_temp + gen_limit + 1 <= TEMP_MAX)
          t = $urandom_range(gen_temp + gen_limit + 1, TEMP_MAX);
        else if (gen_temp - gen_limit - 1 >= 0)
          t = $urandom_range(0, gen_temp - gen_limit - 1);
        else
          t = gen_temp;
      end else begin
        t = $urandom_range(0, TEMP_MAX);
      end
      if ($urandom_range(0, 99) < 85)
        raw = clamp(lvl - spread + int'($urandom_range(0, 2 * spread)), 0, RAW_MAX);
      else
        raw = $urandom_range(0, RAW_MAX);
      queue_item(raw, t);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero average, step limit edges, ring wrap, spikes
    queue_item(0, 3700);
    queue_item(500, 9000);
    queue_item(1000, 3900);
    queue_item(1000, 4101);
    queue_item(1000, 3800);
    queue_item(1000, 3700);
    queue_item(1000, 3600);
    queue_item(1000, 3500);
    queue_item(1000, 3400);
    queue_item(1000, 3300);
    queue_item(1000, 3400);
    queue_item(1000, 3500);
    queue_item(1010, 3600);
    queue_item(990, 3700);
    queue_item(RAW_MAX, 3700);
    queue_item(0, 3700);
    queue_item(1000, 3899);
    queue_item(1000, 3700);
    queue_item(1000, 3499);
    queue_item(1020, 3600);
    wait_drained();

    write_reg(REG_NONE, 32'hFFFF_FFFF);
    random_burst(190, 1200);
    wait_drained();

    // wide step limit, negative temperature factor, top saturation
    set_regs(LIMIT_MAX, 65535, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_item(RAW_MAX, 10000);
    queue_item(RAW_MAX, TEMP_MAX);
    queue_item(0, 0);
    queue_item(RAW_MAX, 6000);
    queue_item(0, TEMP_MAX);
    queue_item(1, 10000);
    random_burst(150, 60000);
    wait_drained();

    // zero step limit, bottom saturation
    set_regs(0, 65535, 16'h7FFF, 32'h8000_0000, 32'h8000_0000);
    queue_item(0, gen_temp);
    queue_item(RAW_MAX, gen_temp);
    random_burst(100, 30000);
    wait_drained();
    write_reg(REG_NOISE_FRACTION, 0);
    random_burst(40, 30000);
    wait_drained();

    // hold the output off while the sender keeps offering
    set_regs(300, 6000, 16'($urandom_range(0, 65535)), $urandom(), $urandom());
    src_gaps_on = 1'b0;
    long_hold_cycles = 500;
    random_burst(200, $urandom_range(0, RAW_MAX));
    wait_drained();
    src_gaps_on = 1'b1;

    set_regs($urandom_range(0, LIMIT_MAX), $urandom_range(500, 30000),
             16'($urandom_range(0, 65535)), $urandom(), $urandom());
    random_burst(175, $urandom_range(0, RAW_MAX));
    wait_drained();

    set_regs($urandom_range(20, 400), $urandom_range(2000, 65535),
             16'($urandom_range(0, 65535)),
             $urandom_range(0, 200000) - 100000, $urandom_range(0, 2000) - 1000);
    random_burst(175, 20);
    wait_drained();

    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    set_regs($urandom_range(100, 2000), $urandom_range(1000, 20000),
             16'($urandom_range(0, 65535)), 32'h0001_0000, $urandom());
    random_burst(175, 65000);
    wait_drained();
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;

    set_regs($urandom_range(0, 3) == 0 ? $urandom_range(0, LIMIT_MAX) : $urandom_range(50, 500),
             $urandom_range(500, 65535), 16'($urandom_range(0, 65535)), $urandom(),
             $urandom());
    random_burst(175, $urandom_range(0, RAW_MAX));
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results: %0d accepted, %0d unstable temperature, %0d noisy",
             results_seen, n_ok, n_unstable, n_noisy);
    $display("%0d register writes over 10 settings, including range limits and long output stalls",
             reg_writes);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sensor_average_reject_calibrate.f]
rtl/sarc_pkg.sv
rtl/sarc_div.sv
rtl/sarc_ctrl.sv
rtl/sarc_datapath.sv
rtl/sensor_average_reject_calibrate.sv
tb/sv/sensor_average_reject_calibrate_tb.sv
